[rtl/quicksort_with_insertion_cutoff_macros.svh]
// Assertion macros for the quicksort block
`ifndef QUICKSORT_WITH_INSERTION_CUTOFF_MACROS_SVH
`define QUICKSORT_WITH_INSERTION_CUTOFF_MACROS_SVH
`ifndef SYNTHESIS
`define QSIC_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define QSIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QSIC_ASSERT(lbl, clk, rst_n, cond)
`define QSIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/qsic_pkg.sv]
// Shared constants and types for the quicksort block
package qsic_pkg;
	localparam int MAX_ITEMS     = 64;
	localparam int CUTOFF        = 10;
	localparam int STACK_ENTRIES = 12;
	localparam int KEY_W         = 64;
	localparam int ADDR_W        = $clog2(MAX_ITEMS);
	localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W         = ADDR_W + 2;
	localparam int NPAIRS        = STACK_ENTRIES / 2;
	localparam int SP_W          = $clog2(NPAIRS + 1);
	localparam int PIDX_W        = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;

	typedef logic signed [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
	} bounds_t;
endpackage

[rtl/qsic_key_ram.sv]
// Key store: one write port, one registered read port
module qsic_key_ram (
	input  logic                     clk,
	input  qsic_pkg::ram_req_t       req,
	output logic [qsic_pkg::KEY_W-1:0] rdata
);
	logic [qsic_pkg::KEY_W-1:0] mem [qsic_pkg::MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

[rtl/qsic_fp_less.sv]
// Shared binary64 less-than compare unit
module qsic_fp_less (
	input  logic [qsic_pkg::KEY_W-1:0] a,
	input  logic [qsic_pkg::KEY_W-1:0] b,
	output logic                       lt
);
	logic nan_a, nan_b, zeros, mag_lt, mag_gt, raw;

	always_comb begin
		nan_a  = (&a[62:52]) && (|a[51:0]);
		nan_b  = (&b[62:52]) && (|b[51:0]);
		zeros  = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
		mag_lt = a[62:0] < b[62:0];
		mag_gt = a[62:0] > b[62:0];
		if (a[63] != b[63]) begin
			raw = a[63];
		end else if (a[63]) begin
			raw = mag_gt;
		end else begin
			raw = mag_lt;
		end
		lt = raw && !nan_a && !nan_b && !zeros;
	end
endmodule

[rtl/qsic_sorter.sv]
// Sort sequencer: median-of-three partition, bound stack and insertion sort
module qsic_sorter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qsic_pkg::CNT_W-1:0]  count,
	input  logic [qsic_pkg::KEY_W-1:0]  rdata,
	output qsic_pkg::ram_req_t          req,
	output logic                        done
);
	localparam logic [4:0] S_IDLE = 5'd0,  S_TOP = 5'd1,   S_MED0 = 5'd2,  S_MED1 = 5'd3;
	localparam logic [4:0] S_MED2 = 5'd4,  S_PIV0 = 5'd5,  S_PIV1 = 5'd6,  S_IINC = 5'd7;
	localparam logic [4:0] S_ICHK = 5'd8,  S_JDEC = 5'd9,  S_JCHK = 5'd10, S_CMP = 5'd11;
	localparam logic [4:0] S_FIN0 = 5'd12, S_FIN1 = 5'd13, S_FIN2 = 5'd14, S_SPLIT = 5'd15;
	localparam logic [4:0] S_POP = 5'd16,  S_X0 = 5'd17,   S_X1 = 5'd18,   S_X2 = 5'd19;
	localparam logic [4:0] S_X3 = 5'd20,   S_IJ = 5'd21,   S_IV = 5'd22,   S_IH = 5'd23;
	localparam logic [4:0] S_IC = 5'd24,   S_DONE = 5'd25;

	localparam int AW = qsic_pkg::ADDR_W;
	localparam int IDX_W_U = qsic_pkg::IDX_W;

	logic [4:0] state_q, ret_q;
	qsic_pkg::idx_t lo_q, hi_q, i_q, j_q, h_q, jj_q, ins_lo_q, ins_hi_q;
	logic [AW-1:0] p_q, q_q;
	logic force_q, swap_q;
	logic [qsic_pkg::KEY_W-1:0] a_q, pv_q, v_q;
	qsic_pkg::bounds_t stack_q [qsic_pkg::NPAIRS];
	logic [qsic_pkg::SP_W-1:0] sp_q;

	logic [qsic_pkg::KEY_W-1:0] op_a, op_b;
	logic lt;
	qsic_pkg::idx_t diff, mid;
	logic [IDX_W_U-1:0] sum_u;
	logic few_keys, go_hi, room;
	qsic_pkg::bounds_t top_b;

	qsic_fp_less u_less (.a(op_a), .b(op_b), .lt(lt));

	always_comb begin
		case (state_q)
			S_ICHK:  begin op_a = rdata; op_b = pv_q; end
			S_JCHK:  begin op_a = pv_q;  op_b = rdata; end
			S_IC:    begin op_a = rdata; op_b = v_q; end
			default: begin op_a = rdata; op_b = a_q; end
		endcase
	end

	always_comb begin
		diff     = hi_q - lo_q;
		few_keys = (diff < qsic_pkg::idx_t'(qsic_pkg::CUTOFF)) || (diff < qsic_pkg::idx_t'(2));
		sum_u    = IDX_W_U'(lo_q) + IDX_W_U'(hi_q);
		mid      = qsic_pkg::idx_t'(sum_u >> 1);
		go_hi    = (hi_q - i_q + qsic_pkg::idx_t'(1)) >= (j_q - lo_q);
		room     = sp_q < qsic_pkg::SP_W'(qsic_pkg::NPAIRS);
		top_b    = stack_q[qsic_pkg::PIDX_W'(sp_q - qsic_pkg::SP_W'(1))];
	end

	always_comb begin
		req = '0;
		unique case (state_q)
			S_X0:   begin req.re = 1'b1; req.raddr = p_q; end
			S_X1:   begin req.re = 1'b1; req.raddr = q_q; end
			S_X2:   begin req.we = force_q | lt; req.waddr = p_q; req.wdata = rdata; end
			S_X3:   begin req.we = swap_q; req.waddr = q_q; req.wdata = a_q; end
			S_PIV0: begin req.re = 1'b1; req.raddr = AW'(lo_q + qsic_pkg::idx_t'(1)); end
			S_IINC: begin req.re = 1'b1; req.raddr = AW'(i_q + qsic_pkg::idx_t'(1)); end
			S_JDEC: begin req.re = 1'b1; req.raddr = AW'(j_q - qsic_pkg::idx_t'(1)); end
			S_FIN0: begin req.re = 1'b1; req.raddr = AW'(j_q); end
			S_FIN1: begin
				req.we = 1'b1; req.waddr = AW'(lo_q + qsic_pkg::idx_t'(1)); req.wdata = rdata;
			end
			S_FIN2: begin req.we = 1'b1; req.waddr = AW'(j_q); req.wdata = pv_q; end
			S_IJ:   begin req.re = (jj_q <= ins_hi_q); req.raddr = AW'(jj_q); end
			S_IH:   begin
				req.re    = (h_q != ins_lo_q);
				req.raddr = AW'(h_q - qsic_pkg::idx_t'(1));
				req.we    = (h_q == ins_lo_q);
				req.waddr = AW'(h_q);
				req.wdata = v_q;
			end
			S_IC:   begin
				req.we = 1'b1; req.waddr = AW'(h_q); req.wdata = lt ? v_q : rdata;
			end
			default: req = '0;
		endcase
	end

	assign done = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			sp_q    <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			h_q     <= '0;
			jj_q    <= '0;
			ins_lo_q <= '0;
			ins_hi_q <= '0;
			p_q     <= '0;
			q_q     <= '0;
			force_q <= 1'b0;
			swap_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						lo_q    <= '0;
						hi_q    <= qsic_pkg::idx_t'(count) - qsic_pkg::idx_t'(1);
						sp_q    <= '0;
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (few_keys) begin
						ins_lo_q <= lo_q;
						ins_hi_q <= hi_q;
						jj_q     <= lo_q + qsic_pkg::idx_t'(1);
						ret_q    <= S_POP;
						state_q  <= S_IJ;
					end else begin
						p_q     <= AW'(mid);
						q_q     <= AW'(lo_q + qsic_pkg::idx_t'(1));
						force_q <= 1'b1;
						ret_q   <= S_MED0;
						state_q <= S_X0;
					end
				end
				S_MED0: begin
					p_q <= AW'(lo_q); q_q <= AW'(hi_q); force_q <= 1'b0;
					ret_q <= S_MED1; state_q <= S_X0;
				end
				S_MED1: begin
					p_q <= AW'(lo_q + qsic_pkg::idx_t'(1)); q_q <= AW'(hi_q); force_q <= 1'b0;
					ret_q <= S_MED2; state_q <= S_X0;
				end
				S_MED2: begin
					p_q <= AW'(lo_q); q_q <= AW'(lo_q + qsic_pkg::idx_t'(1)); force_q <= 1'b0;
					ret_q <= S_PIV0; state_q <= S_X0;
				end
				S_PIV0: begin
					i_q     <= lo_q + qsic_pkg::idx_t'(1);
					j_q     <= hi_q;
					state_q <= S_PIV1;
				end
				S_PIV1: begin
					pv_q    <= rdata;
					state_q <= S_IINC;
				end
				S_IINC: begin
					i_q     <= i_q + qsic_pkg::idx_t'(1);
					state_q <= S_ICHK;
				end
				S_ICHK: begin
					state_q <= ((i_q < hi_q) && lt) ? S_IINC : S_JDEC;
				end
				S_JDEC: begin
					j_q     <= j_q - qsic_pkg::idx_t'(1);
					state_q <= S_JCHK;
				end
				S_JCHK: begin
					state_q <= ((j_q > lo_q) && lt) ? S_JDEC : S_CMP;
				end
				S_CMP: begin
					if (j_q < i_q) begin
						state_q <= S_FIN0;
					end else begin
						p_q <= AW'(i_q); q_q <= AW'(j_q); force_q <= 1'b1;
						ret_q <= S_IINC; state_q <= S_X0;
					end
				end
				S_FIN0: state_q <= S_FIN1;
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: state_q <= S_SPLIT;
				S_SPLIT: begin
					if (go_hi) begin
						hi_q     <= j_q - qsic_pkg::idx_t'(1);
						ins_lo_q <= i_q;
						ins_hi_q <= hi_q;
						jj_q     <= i_q + qsic_pkg::idx_t'(1);
						if (room) begin
							stack_q[qsic_pkg::PIDX_W'(sp_q)] <= '{lo: AW'(i_q), hi: AW'(hi_q)};
						end
					end else begin
						lo_q     <= i_q;
						ins_lo_q <= lo_q;
						ins_hi_q <= j_q - qsic_pkg::idx_t'(1);
						jj_q     <= lo_q + qsic_pkg::idx_t'(1);
						if (room) begin
							stack_q[qsic_pkg::PIDX_W'(sp_q)] <=
								'{lo: AW'(lo_q), hi: AW'(j_q - qsic_pkg::idx_t'(1))};
						end
					end
					if (room) begin
						sp_q    <= sp_q + qsic_pkg::SP_W'(1);
						state_q <= S_TOP;
					end else begin
						ret_q   <= S_TOP;
						state_q <= S_IJ;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_DONE;
					end else begin
						sp_q    <= sp_q - qsic_pkg::SP_W'(1);
						lo_q    <= qsic_pkg::idx_t'(top_b.lo);
						hi_q    <= qsic_pkg::idx_t'(top_b.hi);
						state_q <= S_TOP;
					end
				end
				S_X0: state_q <= S_X1;
				S_X1: begin
					a_q     <= rdata;
					state_q <= S_X2;
				end
				S_X2: begin
					swap_q  <= force_q | lt;
					state_q <= S_X3;
				end
				S_X3: state_q <= ret_q;
				S_IJ: begin
					state_q <= (jj_q <= ins_hi_q) ? S_IV : ret_q;
				end
				S_IV: begin
					v_q     <= rdata;
					h_q     <= jj_q;
					state_q <= S_IH;
				end
				S_IH: begin
					if (h_q == ins_lo_q) begin
						jj_q    <= jj_q + qsic_pkg::idx_t'(1);
						state_q <= S_IJ;
					end else begin
						state_q <= S_IC;
					end
				end
				S_IC: begin
					if (lt) begin
						jj_q    <= jj_q + qsic_pkg::idx_t'(1);
						state_q <= S_IJ;
					end else begin
						h_q     <= h_q - qsic_pkg::idx_t'(1);
						state_q <= S_IH;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/quicksort_with_insertion_cutoff.sv]
// Top level: key loading, sort start and ordered key streaming
// Keys are loaded one word per cycle into a 64-entry store; the word with tlast set
// starts an in-place sort on the store's write and read ports with one shared
// compare unit, and the input is held off until the whole set has left. A partition
// step reads a key and compares it, a compare-and-exchange reads both keys and
// writes them back, and an insertion shift reads a key, compares and writes, so a
// random set of n keys needs on the order of n log n scan steps while adverse data
// grows towards the square of n. Sorted keys then leave one word at a time, the last
// with tlast, and tuser flags a set from which keys beyond capacity were dropped.
`include "quicksort_with_insertion_cutoff_macros.svh"
module quicksort_with_insertion_cutoff (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // key_bits[63:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // sorted_bits[63:0]
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // overflowed
);
	localparam logic [1:0] T_LOAD = 2'd0, T_SORT = 2'd1, T_RD = 2'd2, T_OUT = 2'd3;

	logic [1:0] state_q;
	logic [qsic_pkg::CNT_W-1:0] cnt_q, k_q;
	logic ovf_q;
	qsic_pkg::ram_req_t sort_req, local_req, ram_req;
	logic [qsic_pkg::KEY_W-1:0] rdata;
	logic sort_done, in_acc, out_acc, full;

	assign full    = cnt_q == qsic_pkg::CNT_W'(qsic_pkg::MAX_ITEMS);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	assign s_axis_tready = (state_q == T_LOAD);
	assign m_axis_tvalid = (state_q == T_OUT);
	assign m_axis_tdata  = rdata;
	assign m_axis_tlast  = (k_q == cnt_q - qsic_pkg::CNT_W'(1));
	assign m_axis_tuser  = ovf_q;

	always_comb begin
		local_req       = '0;
		local_req.we    = in_acc && !full;
		local_req.waddr = cnt_q[qsic_pkg::ADDR_W-1:0];
		local_req.wdata = s_axis_tdata;
		local_req.re    = (state_q == T_RD);
		local_req.raddr = k_q[qsic_pkg::ADDR_W-1:0];
		ram_req         = (state_q == T_SORT) ? sort_req : local_req;
	end

	qsic_key_ram u_ram (.clk(clk), .req(ram_req), .rdata(rdata));

	qsic_sorter u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc && s_axis_tlast),
		.count  (full ? cnt_q : cnt_q + qsic_pkg::CNT_W'(1)),
		.rdata  (rdata),
		.req    (sort_req),
		.done   (sort_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_LOAD;
			cnt_q   <= '0;
			k_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				T_LOAD: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + qsic_pkg::CNT_W'(1);
						end
						if (s_axis_tlast) begin
							state_q <= T_SORT;
						end
					end
				end
				T_SORT: begin
					if (sort_done) begin
						k_q     <= '0;
						state_q <= T_RD;
					end
				end
				T_RD: state_q <= T_OUT;
				T_OUT: begin
					if (out_acc) begin
						if (m_axis_tlast) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= T_LOAD;
						end else begin
							k_q     <= k_q + qsic_pkg::CNT_W'(1);
							state_q <= T_RD;
						end
					end
				end
				default: state_q <= T_LOAD;
			endcase
		end
	end

	`QSIC_ASSERT(a_no_overlap, clk, arst_n, !(s_axis_tready && m_axis_tvalid))
	`QSIC_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= qsic_pkg::CNT_W'(qsic_pkg::MAX_ITEMS))
	`QSIC_ASSERT_NEXT(a_reload, clk, arst_n, out_acc && m_axis_tlast, s_axis_tready && cnt_q == '0)
	`QSIC_ASSERT_NEXT(a_sort_on_last, clk, arst_n, in_acc && s_axis_tlast, !s_axis_tready)
endmodule

[verif/tb.sv]
// Testbench for the quicksort block: sends key sets, predicts the sorted output and checks it
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] key;
		logic        last;
		logic        ovf;
	} sorted_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	sorted_word_t sorted_q[$];
	logic [63:0]  set_keys[$];
	bit           set_ovf;
	int           errors;
	int           idle_sender;
	int           stall_receiver;
	bit           hold_off;
	int           quiet_cycles;
	bit           timed_out;

	quicksort_with_insertion_cutoff dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic bit key_below(logic [63:0] a, logic [63:0] b);
		return $bitstoreal(a) < $bitstoreal(b);
	endfunction

	// Insertion sort by IEEE order gives the same sequence as the block for distinct
	// values; equal values (+0/-0, duplicates) may differ in order, so expectations
	// are built from the block's own algorithm below.
	function automatic void insertion_range(ref logic [63:0] a[qsic_pkg::MAX_ITEMS],
						input int lo, hi);
		int j, i;
		logic [63:0] v;
		for (j = lo + 1; j <= hi; j++) begin
			v = a[j];
			for (i = j - 1; i >= lo; i--) begin
				if (key_below(a[i], v))
					break;
				a[i + 1] = a[i];
			end
			a[i + 1] = v;
		end
	endfunction

	function automatic void quicksort_keys(ref logic [63:0] a[qsic_pkg::MAX_ITEMS],
					       input int n);
		int lo, hi, mid, i, j, top;
		int bnd[qsic_pkg::STACK_ENTRIES];
		logic [63:0] pivot, t;
		lo = 0;
		hi = n - 1;
		top = 0;
		forever begin
			if (hi - lo < qsic_pkg::CUTOFF || hi - lo < 2) begin
				insertion_range(a, lo, hi);
				if (top < 2)
					break;
				top -= 2;
				lo = bnd[top];
				hi = bnd[top + 1];
				continue;
			end
			mid = (lo + hi) / 2;
			t = a[mid]; a[mid] = a[lo + 1]; a[lo + 1] = t;
			if (key_below(a[hi], a[lo])) begin
				t = a[lo]; a[lo] = a[hi]; a[hi] = t;
			end
			if (key_below(a[hi], a[lo + 1])) begin
				t = a[lo + 1]; a[lo + 1] = a[hi]; a[hi] = t;
			end
			if (key_below(a[lo + 1], a[lo])) begin
				t = a[lo]; a[lo] = a[lo + 1]; a[lo + 1] = t;
			end
			i = lo + 1;
			j = hi;
			pivot = a[lo + 1];
			forever begin
				do i++; while (i < hi && key_below(a[i], pivot));
				do j--; while (j > lo && key_below(pivot, a[j]));
				if (j < i)
					break;
				t = a[i]; a[i] = a[j]; a[j] = t;
			end
			a[lo + 1] = a[j];
			a[j] = pivot;
			if (hi - i + 1 >= j - lo) begin
				if (top + 2 <= qsic_pkg::STACK_ENTRIES) begin
					bnd[top] = i; bnd[top + 1] = hi; top += 2;
				end else
					insertion_range(a, i, hi);
				hi = j - 1;
			end else begin
				if (top + 2 <= qsic_pkg::STACK_ENTRIES) begin
					bnd[top] = lo; bnd[top + 1] = j - 1; top += 2;
				end else
					insertion_range(a, lo, j - 1);
				lo = i;
			end
		end
	endfunction

	function automatic void predict_set();
		logic [63:0] a[qsic_pkg::MAX_ITEMS];
		int n;
		sorted_word_t w;
		n = set_keys.size();
		for (int k = 0; k < n; k++)
			a[k] = set_keys[k];
		quicksort_keys(a, n);
		for (int k = 0; k < n; k++) begin
			w.key = a[k];
			w.last = (k == n - 1);
			w.ovf = set_ovf;
			sorted_q.push_back(w);
		end
		set_keys.delete();
		set_ovf = 0;
	endfunction

	task automatic send_key(logic [63:0] key, bit fin);
		@(negedge clk);
		while (idle_sender > 0 && $urandom_range(99) < idle_sender) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= key;
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (set_keys.size() < qsic_pkg::MAX_ITEMS)
			set_keys.push_back(key);
		else
			set_ovf = 1;
		if (fin)
			predict_set();
	endtask

	function automatic logic [63:0] rand_key();
		logic [63:0] k;
		case ($urandom_range(5))
			0: k = {1'b0, 11'h7ff, 52'h0};
			1: k = {1'b1, 11'h7ff, 52'h0};
			2: k = {1'($urandom_range(1)), 11'h000, $urandom, 20'($urandom)};
			3: k = {1'($urandom_range(1)), 11'($urandom_range(1020, 1030)),
				52'($urandom_range(3))};
			default: k = {$urandom, $urandom};
		endcase
		// drop NaN patterns
		if (k[62:52] == 11'h7ff && k[51:0] != 0)
			k[51:0] = 0;
		return k;
	endfunction

	task automatic send_set(int n);
		for (int k = 0; k < n; k++)
			send_key(rand_key(), k == n - 1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 0;
		while (sorted_q.size() != 0 && !timed_out)
			@(negedge clk);
	endtask

	task automatic test_directed();
		send_key(64'h0000_0000_0000_0000, 1);
		send_key(64'h8000_0000_0000_0000, 0);
		send_key(64'h0000_0000_0000_0000, 1);
		send_key(64'hffef_ffff_ffff_ffff, 0);
		send_key(64'h7fef_ffff_ffff_ffff, 0);
		send_key(64'h0000_0000_0000_0001, 0);
		send_key(64'h8000_0000_0000_0001, 0);
		send_key(64'h7ff0_0000_0000_0000, 0);
		send_key(64'hfff0_0000_0000_0000, 0);
		send_key(64'h3ff0_0000_0000_0000, 0);
		send_key(64'h3ff0_0000_0000_0000, 0);
		send_key(64'hbff0_0000_0000_0000, 0);
		send_key(64'h5555_5555_5555_5555, 0);
		send_key(64'h2aaa_aaaa_aaaa_aaaa, 0);
		send_key(64'hd555_5555_5555_5555, 1);
		wait_drained();
	endtask

	task automatic test_sizes();
		for (int k = 0; k < 4; k++)
			send_set($urandom_range(1, 12));
		wait_drained();
	endtask

	task automatic test_sorted_input();
		logic [63:0] v;
		for (int k = 0; k < qsic_pkg::MAX_ITEMS; k++) begin
			v = $realtobits(real'(k));
			send_key(v, k == qsic_pkg::MAX_ITEMS - 1);
		end
		for (int k = 0; k < 24; k++) begin
			v = $realtobits(real'(24 - k));
			send_key(v, k == 23);
		end
		wait_drained();
	endtask

	task automatic test_overflow();
		send_set(qsic_pkg::MAX_ITEMS + 3);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_off = 1;
		send_set(20);
		send_set(10);
		wait_drained();
	endtask

	task automatic test_idling();
		int sidle[4] = '{0, 81, 0, 24};
		int rstall[4] = '{0, 0, 81, 24};
		for (int p = 0; p < 4; p++) begin
			idle_sender = sidle[p];
			stall_receiver = rstall[p];
			for (int k = 0; k < 2; k++)
				send_set($urandom_range(1, 20));
			wait_drained();
		end
		idle_sender = 0;
		stall_receiver = 0;
	endtask

	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (2000) @(negedge clk);
				hold_off = 0;
			end
			m_axis_tready <= !(stall_receiver > 0 && $urandom_range(99) < stall_receiver);
		end
	end

	always @(posedge clk) begin
		sorted_word_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sorted_q.size() == 0) begin
				$error("unexpected word %h", m_axis_tdata);
				errors++;
			end else begin
				w = sorted_q.pop_front();
				if (m_axis_tdata !== w.key) begin
					$error("sorted_bits: expected %h, got %h", w.key, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== w.last) begin
					$error("last_out: expected %b, got %b", w.last, m_axis_tlast);
					errors++;
				end
				if (m_axis_tuser !== w.ovf) begin
					$error("overflowed: expected %b, got %b", w.ovf, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 200000 && !timed_out) begin
			timed_out = 1;
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		timed_out = 0;
		hold_off = 0;
		idle_sender = 0;
		stall_receiver = 0;
		set_ovf = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_sizes();
		test_sorted_input();
		test_overflow();
		test_backpressure();
		test_idling();
		wait_drained();
		repeat (200) @(negedge clk);
		if (errors == 0 && sorted_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/qsic_pkg.sv
rtl/qsic_key_ram.sv
rtl/qsic_fp_less.sv
rtl/qsic_sorter.sv
rtl/quicksort_with_insertion_cutoff.sv
verif/tb.sv
